FILE: hdl/swwm_pkg.sv
package swwm_pkg;

  localparam int unsigned WinDepth   = 16;
  localparam int unsigned PatternMax = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LenW       = 5;
  localparam int unsigned PatIdxW    = $clog2(PatternMax);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned NumCmp     = (WinDepth < PatternMax) ? WinDepth : PatternMax;

  localparam logic [ByteW-1:0] WildcardByte = 8'h2A;
  localparam logic [ByteW-1:0] UpperFirst   = 8'h41;
  localparam logic [ByteW-1:0] UpperLast    = 8'h5A;
  localparam logic [ByteW-1:0] CaseOffset   = 8'h20;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatLow  = 3'd0,
    CfgPatHigh = 3'd1,
    CfgPatLen  = 3'd2,
    CfgFold    = 3'd3
  } cfg_reg_e;

  // Control shared by every window cell.
  typedef struct packed {
    logic shift;
    logic fold;
  } cell_ctrl_t;

  typedef struct packed {
    logic [ByteW-1:0] oldest_byte;
    logic             match_found;
    logic [LenW-1:0]  matched_length;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

  function automatic logic [ByteW-1:0] fold_lower(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = b;
    if (b >= UpperFirst && b <= UpperLast) begin
      r = b + CaseOffset;
    end
    return r;
  endfunction

endpackage

FILE: hdl/swwm_cell.sv
module swwm_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  swwm_pkg::cell_ctrl_t             ctrl_i,
  input  logic [swwm_pkg::ByteW-1:0]       byte_i,
  input  logic [swwm_pkg::ByteW-1:0]       pat_byte_i,
  input  logic                             cmp_en_i,
  output logic [swwm_pkg::ByteW-1:0]       byte_o,
  output logic                             hit_o
);

  logic [swwm_pkg::ByteW-1:0] byte_q;
  logic [swwm_pkg::ByteW-1:0] s_cmp;
  logic [swwm_pkg::ByteW-1:0] p_cmp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  // The compare looks at the byte this cell will hold after the shift.
  always_comb begin
    s_cmp = ctrl_i.fold ? swwm_pkg::fold_lower(byte_i) : byte_i;
    p_cmp = ctrl_i.fold ? swwm_pkg::fold_lower(pat_byte_i) : pat_byte_i;
    hit_o = !cmp_en_i || (pat_byte_i == swwm_pkg::WildcardByte) || (s_cmp == p_cmp);
  end

  assign byte_o = byte_q;

endmodule

FILE: hdl/swwm_out_buf.sv
module swwm_out_buf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  swwm_pkg::result_t        data_i,
  output logic                     ready_o,
  output logic                     valid_o,
  input  logic                     out_ready_i,
  output swwm_pkg::result_t        data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  swwm_pkg::result_t out_data_q, out_data_d;
  swwm_pkg::result_t skid_data_q, skid_data_d;
  logic              pop;

  assign pop     = out_valid_q && out_ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = push_i;
        skid_data_d  = data_i;
      end else begin
        out_valid_d = push_i;
        out_data_d  = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("beat pushed while both entries are full");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("stalled beat was not kept in the skid entry");

  a_pop_refills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && skid_valid_q) |=> (out_valid_q && out_data_q == $past(skid_data_q)))
    else $error("skid entry lost on output pop");

endmodule

FILE: hdl/sliding_window_wildcard_matcher.sv
// Channel   Dir  Signals                             Content
// s_axis    in   s_axis_tvalid/tready/tdata[7:0]     byte_in
// m_axis    out  m_axis_tvalid/tready/tdata[15:0]    matched_length, match_found, oldest_byte
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i     pattern low/high, length, ignore case
//
// One byte is accepted per clock while s_axis_tready is high; its result is registered in the output buffer.
// The window is a chain of cells that shift one step per accepted byte; each cell compares
// its incoming byte with its pattern byte in the same cycle, and the hits are ANDed.
// A two-entry output buffer keeps input acceptance going for one more byte while m_axis stalls;
// s_axis_tready drops only when both entries are full.
// Reset clears the window to zeros, the configuration to zero and empties the output buffer.
module sliding_window_wildcard_matcher (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] byte_in
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [4:0] matched_length, [5] match_found, [13:6] oldest_byte, [15:14] zero
  output logic [swwm_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [swwm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [swwm_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned D = swwm_pkg::WinDepth;

  logic [swwm_pkg::CfgDataW-1:0] pat_low_q, pat_high_q;
  logic [swwm_pkg::LenW-1:0]     pat_len_q;
  logic                          fold_q;

  logic [swwm_pkg::ByteW-1:0] pat_bytes [swwm_pkg::PatternMax];
  logic [swwm_pkg::ByteW-1:0] win_in  [D];
  logic [swwm_pkg::ByteW-1:0] win_out [D];
  logic [D-1:0]               hits;
  logic                       accept;
  logic                       len_ok;
  logic                       match;
  swwm_pkg::cell_ctrl_t       ctrl;
  swwm_pkg::result_t          result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
      fold_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (swwm_pkg::cfg_reg_e'(cfg_idx_i))
        swwm_pkg::CfgPatLow:  pat_low_q  <= cfg_data_i;
        swwm_pkg::CfgPatHigh: pat_high_q <= cfg_data_i;
        swwm_pkg::CfgPatLen:  pat_len_q  <= cfg_data_i[swwm_pkg::LenW-1:0];
        swwm_pkg::CfgFold:    fold_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      pat_bytes[j]     = pat_low_q[j*8 +: 8];
      pat_bytes[j + 8] = pat_high_q[j*8 +: 8];
    end
  end

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign ctrl.shift = accept;
  assign ctrl.fold  = fold_q;

  for (genvar k = 0; k < D; k++) begin : g_cell
    logic [swwm_pkg::ByteW-1:0] pat_sel;
    logic                       cmp_en;

    if (k == 0) begin : g_head
      assign win_in[k] = s_axis_tdata;
    end else begin : g_link
      assign win_in[k] = win_out[k-1];
    end

    // Cell k holds the newest-but-k byte, which lines up with pattern byte len-1-k.
    if (k < swwm_pkg::NumCmp) begin : g_cmp
      logic [swwm_pkg::LenW-1:0] pidx;
      assign pidx    = pat_len_q - swwm_pkg::LenW'(k + 1);
      assign cmp_en  = pat_len_q > swwm_pkg::LenW'(k);
      assign pat_sel = pat_bytes[pidx[swwm_pkg::PatIdxW-1:0]];
    end else begin : g_nocmp
      assign cmp_en  = 1'b0;
      assign pat_sel = '0;
    end

    swwm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .byte_i     (win_in[k]),
      .pat_byte_i (pat_sel),
      .cmp_en_i   (cmp_en),
      .byte_o     (win_out[k]),
      .hit_o      (hits[k])
    );
  end

  assign len_ok = (pat_len_q != '0)
               && (32'(pat_len_q) <= swwm_pkg::PatternMax)
               && (32'(pat_len_q) <= D);
  assign match  = len_ok && (&hits);

  assign result.matched_length = match ? pat_len_q : '0;
  assign result.match_found    = match;
  assign result.oldest_byte    = win_in[D-1];

  swwm_pkg::result_t out_data;

  swwm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (result),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .data_o      (out_data)
  );

  assign m_axis_tdata = swwm_pkg::OutDataW'(out_data);

endmodule
